// ===== design/ijvm_eu_pkg.sv =====
// Shared constants, opcode codes, decoded-instruction type and sequencer states
// for the IJVM execute unit. No dependencies.
package ijvm_eu_pkg;

    localparam int STACK_DEPTH = 4096;
    localparam int MAX_ARGS    = 256;
    localparam int SA          = $clog2(STACK_DEPTH);
    localparam int AE          = SA + 1;
    localparam int LW          = SA + 18;
    localparam int CW          = $clog2(MAX_ARGS + 1);

    localparam logic [4:0] CMD_NOP       = 5'd0;
    localparam logic [4:0] CMD_BIPUSH    = 5'd1;
    localparam logic [4:0] CMD_DUP       = 5'd2;
    localparam logic [4:0] CMD_ERR       = 5'd3;
    localparam logic [4:0] CMD_GOTO      = 5'd4;
    localparam logic [4:0] CMD_HALT      = 5'd5;
    localparam logic [4:0] CMD_IADD      = 5'd6;
    localparam logic [4:0] CMD_IAND      = 5'd7;
    localparam logic [4:0] CMD_IFEQ      = 5'd8;
    localparam logic [4:0] CMD_IFLT      = 5'd9;
    localparam logic [4:0] CMD_ICMPEQ    = 5'd10;
    localparam logic [4:0] CMD_IINC      = 5'd11;
    localparam logic [4:0] CMD_ILOAD     = 5'd12;
    localparam logic [4:0] CMD_IN        = 5'd13;
    localparam logic [4:0] CMD_INVOKE    = 5'd14;
    localparam logic [4:0] CMD_IOR       = 5'd15;
    localparam logic [4:0] CMD_IRETURN   = 5'd16;
    localparam logic [4:0] CMD_ISTORE    = 5'd17;
    localparam logic [4:0] CMD_ISUB      = 5'd18;
    localparam logic [4:0] CMD_LDCW      = 5'd19;
    localparam logic [4:0] CMD_OUT       = 5'd20;
    localparam logic [4:0] CMD_POP       = 5'd21;
    localparam logic [4:0] CMD_SWAP      = 5'd22;
    localparam logic [4:0] CMD_WIDE      = 5'd23;

    typedef enum logic [4:0] {
        OP_NOP, OP_BIPUSH, OP_DUP, OP_ERR, OP_GOTO, OP_HALT, OP_IADD, OP_IAND,
        OP_IFEQ, OP_IFLT, OP_ICMPEQ, OP_IINC, OP_ILOAD, OP_IN, OP_INVOKE, OP_IOR,
        OP_IRET, OP_ISTORE, OP_ISUB, OP_LDCW, OP_OUT, OP_POP, OP_SWAP, OP_WIDE
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_FETCH_B, ST_EXEC, ST_SWAP2, ST_RET2, ST_RET3, ST_COPY,
        ST_CALL1, ST_CALL2, ST_CALL3, ST_TOP_RD, ST_TOP
    } st_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] pc;
        logic [7:0]  hi;
        logic [7:0]  lo;
        logic [31:0] pool;
        logic [15:0] nargs;
        logic [15:0] nlocals;
        logic [7:0]  in_char;
        logic        in_eof;
        logic [1:0]  pops;
        logic [1:0]  pushes;
        logic        chk;
    } dec_t;

endpackage

// ===== design/ijvm_eu_if.sv =====
// Valid/ready channel interfaces for instruction items and result items.
// Depends on nothing.
interface ijvm_eu_in_if;
    logic               valid;
    logic               ready;
    logic [4:0]         cmd;
    logic [15:0]        current_pc;
    logic [7:0]         operand_hi;
    logic [7:0]         operand_lo;
    logic signed [31:0] pool_word;
    logic [15:0]        method_args;
    logic [15:0]        method_locals;
    logic [7:0]         in_char;
    logic               in_eof;

    modport source (output valid, cmd, current_pc, operand_hi, operand_lo, pool_word,
                    method_args, method_locals, in_char, in_eof, input ready);
    modport sink (input valid, cmd, current_pc, operand_hi, operand_lo, pool_word,
                  method_args, method_locals, in_char, in_eof, output ready);
endinterface

interface ijvm_eu_out_if;
    logic               valid;
    logic               ready;
    logic [15:0]        next_pc;
    logic               out_valid;
    logic [7:0]         out_char;
    logic               halted;
    logic               fault;
    logic signed [31:0] top_value;

    modport source (output valid, next_pc, out_valid, out_char, halted, fault, top_value,
                    input ready);
    modport sink (input valid, next_pc, out_valid, out_char, halted, fault, top_value,
                  output ready);
endinterface

// ===== design/ijvm_execute_unit.sv =====
// IJVM execute unit top level: program size register, front-end queue and back-end sequencer.
// Depends on ijvm_eu_pkg, ijvm_eu_if, ijvm_eu_front, ijvm_eu_back.
//
// Executes one decoded IJVM instruction per input transaction and returns one result
// transaction each. Instructions run one at a time on a stack memory with a write port and
// a registered read port (one write, one registered read per cycle); the front queue holds
// two more. Ops without stack reads (NOP, GOTO, HALT, WIDE, POP, BIPUSH, LDC_W, IN, faults)
// go straight to TOP_RD; single-read ops pass EXEC first, two-operand ops FETCH_B and EXEC,
// SWAP adds SWAP2, IRETURN adds RET2 and RET3, INVOKEVIRTUAL runs COPY (unless it has no
// arguments), then CALL1 to CALL3. The user must write program_size through cfg_we/cfg_wdata
// only while no instruction is in flight; the block itself does not enforce this.
module ijvm_execute_unit import ijvm_eu_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [15:0]    cfg_wdata,
    ijvm_eu_in_if.sink     in_ch,
    ijvm_eu_out_if.source  out_ch
);

    logic [15:0] program_size_reg, program_size_next;
    logic        q_valid, q_ready;
    dec_t        q_item;

    assign program_size_next = cfg_we ? cfg_wdata : program_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            program_size_reg <= 16'd0;
        end
        else
        begin
            program_size_reg <= program_size_next;
        end
    end

    ijvm_eu_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    ijvm_eu_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .program_size (program_size_reg),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_item       (q_item),
        .out_ch       (out_ch)
    );

endmodule

// ===== design/ijvm_eu_front.sv =====
// Front end: accepts instruction transactions, classifies them and holds them
// in a two-entry queue. Depends on ijvm_eu_pkg and ijvm_eu_in_if.
module ijvm_eu_front import ijvm_eu_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    ijvm_eu_in_if.sink     in_ch,
    output logic           q_valid,
    input  logic           q_ready,
    output dec_t           q_item
);

    dec_t       dec;
    dec_t       slot_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    always_comb
    begin
        dec.pc      = in_ch.current_pc;
        dec.hi      = in_ch.operand_hi;
        dec.lo      = in_ch.operand_lo;
        dec.pool    = in_ch.pool_word;
        dec.nargs   = in_ch.method_args;
        dec.nlocals = in_ch.method_locals;
        dec.in_char = in_ch.in_char;
        dec.in_eof  = in_ch.in_eof;
        dec.pops    = 2'd0;
        dec.pushes  = 2'd0;
        dec.chk     = 1'b1;
        dec.op      = OP_ERR;
        unique case (in_ch.cmd)
            CMD_NOP:     begin dec.op = OP_NOP;    dec.chk = 1'b0; end
            CMD_BIPUSH:  begin dec.op = OP_BIPUSH; dec.pushes = 2'd1; end
            CMD_DUP:     begin dec.op = OP_DUP;    dec.pops = 2'd1; dec.pushes = 2'd2; end
            CMD_ERR:     begin dec.op = OP_ERR;    dec.chk = 1'b0; end
            CMD_GOTO:    begin dec.op = OP_GOTO;   dec.chk = 1'b0; end
            CMD_HALT:    begin dec.op = OP_HALT;   dec.chk = 1'b0; end
            CMD_IADD:    begin dec.op = OP_IADD;   dec.pops = 2'd2; dec.pushes = 2'd1; end
            CMD_IAND:    begin dec.op = OP_IAND;   dec.pops = 2'd2; dec.pushes = 2'd1; end
            CMD_IFEQ:    begin dec.op = OP_IFEQ;   dec.pops = 2'd1; end
            CMD_IFLT:    begin dec.op = OP_IFLT;   dec.pops = 2'd1; end
            CMD_ICMPEQ:  begin dec.op = OP_ICMPEQ; dec.pops = 2'd2; end
            CMD_IINC:    begin dec.op = OP_IINC;   dec.chk = 1'b0; end
            CMD_ILOAD:   begin dec.op = OP_ILOAD;  dec.pushes = 2'd1; end
            CMD_IN:      begin dec.op = OP_IN;     dec.pushes = 2'd1; end
            CMD_INVOKE:  begin dec.op = OP_INVOKE; dec.chk = 1'b0; end
            CMD_IOR:     begin dec.op = OP_IOR;    dec.pops = 2'd2; dec.pushes = 2'd1; end
            CMD_IRETURN: begin dec.op = OP_IRET;   dec.chk = 1'b0; end
            CMD_ISTORE:  begin dec.op = OP_ISTORE; dec.pops = 2'd1; end
            CMD_ISUB:    begin dec.op = OP_ISUB;   dec.pops = 2'd2; dec.pushes = 2'd1; end
            CMD_LDCW:    begin dec.op = OP_LDCW;   dec.pushes = 2'd1; end
            CMD_OUT:     begin dec.op = OP_OUT;    dec.pops = 2'd1; end
            CMD_POP:     begin dec.op = OP_POP;    dec.pops = 2'd1; end
            CMD_SWAP:    begin dec.op = OP_SWAP;   dec.pops = 2'd2; dec.pushes = 2'd2; end
            CMD_WIDE:    begin dec.op = OP_WIDE;   dec.chk = 1'b0; end
            default:     begin dec.op = OP_ERR;    dec.chk = 1'b0; end
        endcase
    end

    assign in_ch.ready = (cnt_reg != 2'd2);
    assign push        = in_ch.valid & in_ch.ready;
    assign q_valid     = (cnt_reg != 2'd0);
    assign pop         = q_valid & q_ready;
    assign q_item      = slot_reg[rp_reg];

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= dec;
        end
    end

endmodule

// ===== design/ijvm_eu_back.sv =====
// Back end: sequencer over the stack memory that carries out one queued
// instruction at a time and registers its result. Depends on ijvm_eu_pkg, ijvm_eu_out_if.
module ijvm_eu_back import ijvm_eu_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [15:0]    program_size,
    input  logic           q_valid,
    output logic           q_ready,
    input  dec_t           q_item,
    ijvm_eu_out_if.source  out_ch
);

    st_t            state_reg, state_next;
    logic [SA-1:0]  sp_reg, sp_next, lv_reg, lv_next, addr_reg, addr_next;
    logic [SA-1:0]  newlv_reg, newlv_next, frame_reg, frame_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           wide_reg, wide_next;
    logic [31:0]    a_reg, a_next, b_reg, b_next;
    dec_t           cur_reg, cur_next;
    logic [15:0]    npc_reg, npc_next;
    logic           halt_reg, halt_next, flt_reg, flt_next, ov_reg, ov_next;
    logic [7:0]     oc_reg, oc_next;

    logic           o_valid_reg, o_valid_next, o_load;
    logic [15:0]    o_npc_reg;
    logic           o_ov_reg, o_halt_reg, o_flt_reg;
    logic [7:0]     o_oc_reg;
    logic [31:0]    o_top_reg;

    logic [31:0]    mem [STACK_DEPTH];
    logic [31:0]    rd_reg;
    logic [SA-1:0]  raddr, waddr;
    logic           we;
    logic [31:0]    wdata;

    // dispatch-time checks
    logic [AE-1:0]  sp_ext, need;
    logic           room, flt;
    logic [LW-1:0]  nl, call_top;
    logic [15:0]    idx;
    logic [SA-1:0]  laddr;
    logic           two_read;
    logic [31:0]    op_a, alu;

    always_comb
    begin
        sp_ext   = {1'b0, sp_reg};
        need     = sp_ext - AE'(q_item.pops) + AE'(q_item.pushes);
        room     = (sp_ext >= AE'(q_item.pops)) && (need <= AE'(STACK_DEPTH - 1));
        nl       = LW'(sp_reg) - LW'(q_item.nargs) + LW'(1);
        call_top = nl + LW'(q_item.nargs) + LW'(q_item.nlocals) + LW'(2);
        idx      = (wide_reg && (q_item.op == OP_ILOAD || q_item.op == OP_ISTORE))
                   ? {q_item.hi, q_item.lo} : {8'd0, q_item.hi};
        laddr    = SA'(LW'(lv_reg) + LW'(1) + LW'(idx));
        if (q_item.op == OP_ERR)
        begin
            flt = 1'b1;
        end
        else if (q_item.op == OP_INVOKE)
        begin
            flt = (q_item.nargs > 16'(MAX_ARGS)) || (LW'(sp_reg) < LW'(q_item.nargs))
                  || (call_top > LW'(STACK_DEPTH - 1));
        end
        else if (q_item.op == OP_IRET)
        begin
            flt = (sp_reg == '0) || (lv_reg == '0);
        end
        else
        begin
            flt = q_item.chk && !room;
        end
    end

    always_comb
    begin
        two_read = (cur_reg.op == OP_IADD) || (cur_reg.op == OP_IAND) ||
                   (cur_reg.op == OP_IOR) || (cur_reg.op == OP_ISUB) ||
                   (cur_reg.op == OP_ICMPEQ) || (cur_reg.op == OP_SWAP) ||
                   (cur_reg.op == OP_IRET);
        op_a = two_read ? a_reg : rd_reg;
        unique case (cur_reg.op)
            OP_IADD: alu = a_reg + rd_reg;
            OP_IAND: alu = a_reg & rd_reg;
            OP_IOR:  alu = a_reg | rd_reg;
            default: alu = rd_reg - a_reg;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (flt)
                    begin
                        state_next = ST_TOP_RD;
                    end
                    else
                    begin
                        unique case (q_item.op)
                            OP_DUP, OP_IFEQ, OP_IFLT, OP_OUT, OP_ISTORE, OP_IINC, OP_ILOAD:
                                state_next = ST_EXEC;
                            OP_IADD, OP_IAND, OP_IOR, OP_ISUB, OP_ICMPEQ, OP_SWAP, OP_IRET:
                                state_next = ST_FETCH_B;
                            OP_INVOKE:
                                state_next = (q_item.nargs != 16'd0) ? ST_COPY : ST_CALL1;
                            default:
                                state_next = ST_TOP_RD;
                        endcase
                    end
                end
            end
            ST_FETCH_B: state_next = ST_EXEC;
            ST_EXEC:
            begin
                if (cur_reg.op == OP_SWAP)
                begin
                    state_next = ST_SWAP2;
                end
                else if (cur_reg.op == OP_IRET)
                begin
                    state_next = ST_RET2;
                end
                else
                begin
                    state_next = ST_TOP_RD;
                end
            end
            ST_SWAP2:  state_next = ST_TOP_RD;
            ST_RET2:   state_next = ST_RET3;
            ST_RET3:   state_next = ST_TOP_RD;
            ST_COPY:   state_next = (cnt_reg == CW'(1)) ? ST_CALL1 : ST_COPY;
            ST_CALL1:  state_next = ST_CALL2;
            ST_CALL2:  state_next = ST_CALL3;
            ST_CALL3:  state_next = ST_TOP_RD;
            ST_TOP_RD: state_next = ST_TOP;
            ST_TOP:    state_next = (!o_valid_reg || out_ch.ready) ? ST_IDLE : ST_TOP;
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        sp_next    = sp_reg;
        lv_next    = lv_reg;
        addr_next  = addr_reg;
        newlv_next = newlv_reg;
        frame_next = frame_reg;
        cnt_next   = cnt_reg;
        wide_next  = wide_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        cur_next   = cur_reg;
        npc_next   = npc_reg;
        halt_next  = halt_reg;
        flt_next   = flt_reg;
        ov_next    = ov_reg;
        oc_next    = oc_reg;
        raddr      = sp_reg;
        waddr      = sp_reg;
        wdata      = '0;
        we         = 1'b0;
        o_load     = 1'b0;
        q_ready    = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    cur_next  = q_item;
                    npc_next  = q_item.pc + 16'd1;
                    halt_next = 1'b0;
                    flt_next  = 1'b0;
                    ov_next   = 1'b0;
                    oc_next   = 8'd0;
                    addr_next = laddr;
                    if (flt)
                    begin
                        npc_next  = program_size;
                        halt_next = 1'b1;
                        flt_next  = 1'b1;
                    end
                    else
                    begin
                        unique case (q_item.op)
                            OP_GOTO: npc_next = q_item.pc + {q_item.hi, q_item.lo};
                            OP_HALT:
                            begin
                                npc_next  = program_size;
                                halt_next = 1'b1;
                            end
                            OP_WIDE: wide_next = 1'b1;
                            OP_BIPUSH, OP_LDCW, OP_IN:
                            begin
                                we      = 1'b1;
                                waddr   = sp_reg + SA'(1);
                                sp_next = sp_reg + SA'(1);
                                if (q_item.op == OP_BIPUSH)
                                begin
                                    wdata    = {{24{q_item.hi[7]}}, q_item.hi};
                                    npc_next = q_item.pc + 16'd2;
                                end
                                else if (q_item.op == OP_LDCW)
                                begin
                                    wdata    = q_item.pool;
                                    npc_next = q_item.pc + 16'd3;
                                end
                                else
                                begin
                                    wdata = q_item.in_eof ? 32'd0 : {24'd0, q_item.in_char};
                                end
                            end
                            OP_POP: sp_next = sp_reg - SA'(1);
                            OP_IINC:
                            begin
                                raddr    = laddr;
                                npc_next = q_item.pc + 16'd3;
                            end
                            OP_ILOAD, OP_ISTORE:
                            begin
                                if (q_item.op == OP_ILOAD)
                                begin
                                    raddr = laddr;
                                end
                                npc_next = q_item.pc + (wide_reg ? 16'd3 : 16'd2);
                            end
                            OP_INVOKE:
                            begin
                                newlv_next = SA'(nl);
                                frame_next = SA'(call_top - LW'(1));
                                cnt_next   = CW'(q_item.nargs);
                                raddr      = SA'(nl + LW'(q_item.nargs) - LW'(1));
                                npc_next   = q_item.pool[15:0] + 16'd4;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            ST_FETCH_B:
            begin
                a_next = rd_reg;
                raddr  = (cur_reg.op == OP_IRET) ? lv_reg : sp_reg - SA'(1);
            end
            ST_EXEC:
            begin
                unique case (cur_reg.op)
                    OP_DUP, OP_ILOAD:
                    begin
                        we      = 1'b1;
                        waddr   = sp_reg + SA'(1);
                        wdata   = op_a;
                        sp_next = sp_reg + SA'(1);
                        if (cur_reg.op == OP_ILOAD)
                        begin
                            wide_next = 1'b0;
                        end
                    end
                    OP_IADD, OP_IAND, OP_IOR, OP_ISUB:
                    begin
                        we      = 1'b1;
                        waddr   = sp_reg - SA'(1);
                        wdata   = alu;
                        sp_next = sp_reg - SA'(1);
                    end
                    OP_IFEQ, OP_IFLT:
                    begin
                        sp_next = sp_reg - SA'(1);
                        if ((cur_reg.op == OP_IFEQ) ? (rd_reg == 32'd0) : rd_reg[31])
                        begin
                            npc_next = cur_reg.pc + {cur_reg.hi, cur_reg.lo};
                        end
                        else
                        begin
                            npc_next = cur_reg.pc + 16'd3;
                        end
                    end
                    OP_ICMPEQ:
                    begin
                        sp_next  = sp_reg - SA'(2);
                        npc_next = (a_reg == rd_reg) ? cur_reg.pc + {cur_reg.hi, cur_reg.lo}
                                                     : cur_reg.pc + 16'd3;
                    end
                    OP_IINC:
                    begin
                        we    = 1'b1;
                        waddr = addr_reg;
                        wdata = rd_reg + {{24{cur_reg.lo[7]}}, cur_reg.lo};
                    end
                    OP_ISTORE:
                    begin
                        we        = 1'b1;
                        waddr     = addr_reg;
                        wdata     = rd_reg;
                        sp_next   = sp_reg - SA'(1);
                        wide_next = 1'b0;
                    end
                    OP_OUT:
                    begin
                        sp_next = sp_reg - SA'(1);
                        ov_next = 1'b1;
                        oc_next = rd_reg[7:0];
                    end
                    OP_SWAP:
                    begin
                        we     = 1'b1;
                        waddr  = sp_reg - SA'(1);
                        wdata  = a_reg;
                        b_next = rd_reg;
                    end
                    OP_IRET:
                    begin
                        // rd_reg holds the link pointer
                        addr_next = rd_reg[SA-1:0];
                        raddr     = rd_reg[SA-1:0];
                    end
                    default: ;
                endcase
            end
            ST_SWAP2:
            begin
                we    = 1'b1;
                waddr = sp_reg;
                wdata = b_reg;
            end
            ST_RET2:
            begin
                npc_next = rd_reg[15:0] + 16'd3;
                raddr    = addr_reg + SA'(1);
            end
            ST_RET3:
            begin
                we      = 1'b1;
                waddr   = lv_reg;
                wdata   = a_reg;
                sp_next = lv_reg;
                // saved-lv slot aliasing the return slot sees the return value
                lv_next = (addr_reg + SA'(1) == lv_reg) ? a_reg[SA-1:0] : rd_reg[SA-1:0];
            end
            ST_COPY:
            begin
                // shift one argument up per cycle, top argument first
                we       = 1'b1;
                waddr    = newlv_reg + SA'(cnt_reg);
                wdata    = rd_reg;
                raddr    = newlv_reg + SA'(cnt_reg) - SA'(2);
                cnt_next = cnt_reg - CW'(1);
            end
            ST_CALL1:
            begin
                we    = 1'b1;
                waddr = frame_reg;
                wdata = {16'd0, cur_reg.pc};
            end
            ST_CALL2:
            begin
                we    = 1'b1;
                waddr = newlv_reg;
                wdata = 32'(frame_reg);
            end
            ST_CALL3:
            begin
                we      = 1'b1;
                waddr   = frame_reg + SA'(1);
                wdata   = 32'(lv_reg);
                sp_next = frame_reg + SA'(1);
                lv_next = newlv_reg;
            end
            ST_TOP_RD: ;
            ST_TOP:    o_load = !o_valid_reg || out_ch.ready;
            default: ;
        endcase
    end

    always_comb
    begin
        o_valid_next = o_valid_reg;
        if (o_load)
        begin
            o_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            o_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            sp_reg      <= '0;
            lv_reg      <= '0;
            wide_reg    <= 1'b0;
            cnt_reg     <= '0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            sp_reg      <= sp_next;
            lv_reg      <= lv_next;
            wide_reg    <= wide_next;
            cnt_reg     <= cnt_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        newlv_reg <= newlv_next;
        frame_reg <= frame_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        cur_reg   <= cur_next;
        npc_reg   <= npc_next;
        halt_reg  <= halt_next;
        flt_reg   <= flt_next;
        ov_reg    <= ov_next;
        oc_reg    <= oc_next;
        if (o_load)
        begin
            o_npc_reg  <= npc_reg;
            o_ov_reg   <= ov_reg;
            o_oc_reg   <= oc_reg;
            o_halt_reg <= halt_reg;
            o_flt_reg  <= flt_reg;
            o_top_reg  <= (sp_reg == '0) ? 32'd0 : rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    assign out_ch.valid     = o_valid_reg;
    assign out_ch.next_pc   = o_npc_reg;
    assign out_ch.out_valid = o_ov_reg;
    assign out_ch.out_char  = o_oc_reg;
    assign out_ch.halted    = o_halt_reg;
    assign out_ch.fault     = o_flt_reg;
    assign out_ch.top_value = o_top_reg;

endmodule

// ===== tb/ijvm_execute_unit_tb.sv =====
// Self-checking testbench for ijvm_execute_unit: a directed table, then random
// instruction streams checked against an in-bench model of the stack machine.
// Depends on ijvm_eu_pkg, ijvm_eu_if and the ijvm_execute_unit RTL.
module ijvm_execute_unit_tb;
    import ijvm_eu_pkg::*;

    localparam logic [4:0] CMD_UNKNOWN = 5'd31;
    localparam int         CYCLE_LIMIT = 600000;
    localparam int         RAND_PER_PHASE = 235;

    typedef struct packed {
        logic [4:0]  cmd;
        logic [15:0] pc;
        logic [7:0]  hi;
        logic [7:0]  lo;
        logic [31:0] pool;
        logic [15:0] nargs;
        logic [15:0] nlocals;
        logic [7:0]  ch;
        logic        eof;
    } insn_t;

    typedef struct packed {
        logic [15:0] npc;
        logic        ov;
        logic [7:0]  oc;
        logic        halted;
        logic        fault;
        logic [31:0] top;
    } res_t;

    typedef struct packed {
        insn_t it;
        logic  known;
        res_t  res;
    } dir_row_t;

    typedef struct packed {
        logic [SA-1:0] a;
        logic [31:0]   v;
        logic          w;
    } undo_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;

    ijvm_eu_in_if  insn_ch();
    ijvm_eu_out_if res_ch();

    ijvm_execute_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (insn_ch),
        .out_ch    (res_ch)
    );

    always #10 clk = ~clk;

    // machine model state
    logic [31:0]  stk_mem [STACK_DEPTH];
    bit           stk_wr [STACK_DEPTH];
    int unsigned  sp_w;
    int unsigned  lv_w;
    bit           wide_w;
    logic [15:0]  prog_size_w;
    bit           rd_bad;
    undo_t        undo_log[$];

    res_t         pending_results[$];
    dir_row_t     dir_rows[27];
    int           mismatches;
    int           results_seen;
    int           cycles;
    bit           gaps_on;
    int           hold_left;
    int           stall_left;
    bit           hold_done;
    res_t         mon_exp;

    function automatic logic [31:0] rd_word(input int unsigned a);
        logic [SA-1:0] ad;
        ad = a[SA-1:0];
        if (!stk_wr[ad])
            rd_bad = 1'b1;
        return stk_mem[ad];
    endfunction

    function automatic void wr_word(input int unsigned a, input logic [31:0] v);
        logic [SA-1:0] ad;
        ad = a[SA-1:0];
        undo_log.push_back('{ad, stk_mem[ad], stk_wr[ad]});
        stk_mem[ad] = v;
        stk_wr[ad] = 1'b1;
    endfunction

    function automatic void push_word(input logic [31:0] v);
        sp_w++;
        wr_word(sp_w, v);
    endfunction

    function automatic logic [31:0] pop_word();
        logic [31:0] v;
        v = rd_word(sp_w);
        sp_w--;
        return v;
    endfunction

    function automatic bit has_room(input int unsigned pops, input int unsigned pushes);
        if (sp_w < pops)
            return 1'b0;
        return (sp_w - pops + pushes) <= STACK_DEPTH - 1;
    endfunction

    function automatic void execute_insn(input insn_t it, output res_t r);
        logic [31:0] hi_sx, lo_sx, a, b, rv;
        logic [15:0] off, npc;
        int unsigned newlv, oldlv, link, i;
        bit flt, hlt, ov;
        logic [7:0] oc;
        hi_sx = {{24{it.hi[7]}}, it.hi};
        lo_sx = {{24{it.lo[7]}}, it.lo};
        off = {it.hi, it.lo};
        npc = it.pc + 16'd1;
        flt = 0; hlt = 0; ov = 0; oc = '0;
        rd_bad = 0;
        case (it.cmd)
            CMD_NOP: ;
            CMD_BIPUSH:
                if (!has_room(0, 1)) flt = 1;
                else
                begin
                    push_word(hi_sx);
                    npc = it.pc + 16'd2;
                end
            CMD_DUP:
                if (!has_room(1, 2)) flt = 1;
                else push_word(rd_word(sp_w));
            CMD_GOTO: npc = it.pc + off;
            CMD_HALT:
            begin
                hlt = 1;
                npc = prog_size_w;
            end
            CMD_IADD, CMD_IAND, CMD_IOR, CMD_ISUB:
                if (!has_room(2, 1)) flt = 1;
                else
                begin
                    a = pop_word();
                    b = pop_word();
                    case (it.cmd)
                        CMD_IADD: push_word(a + b);
                        CMD_IAND: push_word(a & b);
                        CMD_IOR:  push_word(a | b);
                        default:  push_word(b - a);
                    endcase
                end
            CMD_IFEQ, CMD_IFLT:
                if (!has_room(1, 0)) flt = 1;
                else
                begin
                    a = pop_word();
                    if ((it.cmd == CMD_IFEQ) ? (a == 0) : a[31]) npc = it.pc + off;
                    else npc = it.pc + 16'd3;
                end
            CMD_ICMPEQ:
                if (!has_room(2, 0)) flt = 1;
                else
                begin
                    a = pop_word();
                    b = pop_word();
                    npc = (a == b) ? it.pc + off : it.pc + 16'd3;
                end
            CMD_IINC:
            begin
                wr_word(lv_w + 1 + it.hi, rd_word(lv_w + 1 + it.hi) + lo_sx);
                npc = it.pc + 16'd3;
            end
            CMD_ILOAD:
                if (!has_room(0, 1)) flt = 1;
                else if (wide_w)
                begin
                    push_word(rd_word(lv_w + 1 + off));
                    npc = it.pc + 16'd3;
                    wide_w = 0;
                end
                else
                begin
                    push_word(rd_word(lv_w + 1 + it.hi));
                    npc = it.pc + 16'd2;
                end
            CMD_IN:
                if (!has_room(0, 1)) flt = 1;
                else push_word(it.eof ? 32'd0 : {24'd0, it.ch});
            CMD_INVOKE:
                if (it.nargs > MAX_ARGS || sp_w < it.nargs) flt = 1;
                else
                begin
                    newlv = sp_w - it.nargs + 1;
                    if (newlv + it.nargs + it.nlocals + 2 > STACK_DEPTH - 1) flt = 1;
                    else
                    begin
                        // shift args up one slot; the old OBJREF slot takes the link
                        for (i = it.nargs; i > 0; i--)
                            wr_word(newlv + i, rd_word(newlv + i - 1));
                        oldlv = lv_w;
                        lv_w = newlv;
                        sp_w = newlv + it.nargs + it.nlocals;
                        push_word({16'd0, it.pc});
                        wr_word(newlv, sp_w);
                        push_word(oldlv);
                        npc = it.pool[15:0] + 16'd4;
                    end
                end
            CMD_IRETURN:
                if (sp_w < 1 || lv_w == 0) flt = 1;
                else
                begin
                    rv = pop_word();
                    a = rd_word(lv_w);
                    link = a[SA-1:0];
                    b = rd_word(link);
                    npc = b[15:0] + 16'd3;
                    sp_w = lv_w;
                    wr_word(sp_w, rv);
                    a = rd_word(link + 1);
                    lv_w = a[SA-1:0];
                end
            CMD_ISTORE:
                if (!has_room(1, 0)) flt = 1;
                else
                begin
                    a = pop_word();
                    if (wide_w)
                    begin
                        wr_word(lv_w + 1 + off, a);
                        npc = it.pc + 16'd3;
                        wide_w = 0;
                    end
                    else
                    begin
                        wr_word(lv_w + 1 + it.hi, a);
                        npc = it.pc + 16'd2;
                    end
                end
            CMD_LDCW:
                if (!has_room(0, 1)) flt = 1;
                else
                begin
                    push_word(it.pool);
                    npc = it.pc + 16'd3;
                end
            CMD_OUT:
                if (!has_room(1, 0)) flt = 1;
                else
                begin
                    a = pop_word();
                    oc = a[7:0];
                    ov = 1;
                end
            CMD_POP:
                if (!has_room(1, 0)) flt = 1;
                else a = pop_word();
            CMD_SWAP:
                if (!has_room(2, 2)) flt = 1;
                else
                begin
                    a = pop_word();
                    b = pop_word();
                    push_word(a);
                    push_word(b);
                end
            CMD_WIDE: wide_w = 1;
            default: flt = 1;  // ERR and unused codes
        endcase
        if (flt)
        begin
            hlt = 1;
            npc = prog_size_w;
        end
        r.npc = npc;
        r.ov = ov;
        r.oc = oc;
        r.halted = hlt;
        r.fault = flt;
        r.top = (sp_w == 0) ? 32'd0 : rd_word(sp_w);
    endfunction

    function automatic insn_t draw_insn();
        insn_t it;
        int k;
        it.pc = 16'($urandom);
        it.hi = 8'($urandom);
        it.lo = 8'($urandom);
        it.pool = $urandom;
        it.nargs = 16'($urandom_range(0, (sp_w < 6) ? sp_w : 6));
        it.nlocals = 16'($urandom_range(0, 4));
        it.ch = 8'($urandom);
        it.eof = ($urandom_range(0, 3) == 0);
        k = $urandom_range(0, 99);
        if (k < 6)
        begin
            it.cmd = 5'($urandom_range(0, 31));
            return it;
        end
        if (sp_w < 3 && k < 50)
            case ($urandom_range(0, 3))
                0: it.cmd = CMD_BIPUSH;
                1: it.cmd = CMD_LDCW;
                2: it.cmd = CMD_IN;
                default: it.cmd = CMD_ILOAD;
            endcase
        else if (sp_w > 40 && k < 40)
            case ($urandom_range(0, 3))
                0: it.cmd = CMD_IRETURN;
                1: it.cmd = CMD_POP;
                2: it.cmd = CMD_OUT;
                default: it.cmd = CMD_IADD;
            endcase
        else
            case ($urandom_range(0, 21))
                0: it.cmd = CMD_BIPUSH;
                1: it.cmd = CMD_LDCW;
                2: it.cmd = CMD_IN;
                3: it.cmd = CMD_DUP;
                4: it.cmd = CMD_IADD;
                5: it.cmd = CMD_ISUB;
                6: it.cmd = CMD_IAND;
                7: it.cmd = CMD_IOR;
                8: it.cmd = CMD_SWAP;
                9: it.cmd = CMD_POP;
                10: it.cmd = CMD_OUT;
                11: it.cmd = CMD_IFEQ;
                12: it.cmd = CMD_IFLT;
                13: it.cmd = CMD_ICMPEQ;
                14: it.cmd = CMD_GOTO;
                15: it.cmd = CMD_ISTORE;
                16: it.cmd = CMD_ILOAD;
                17: it.cmd = CMD_IINC;
                18: it.cmd = CMD_WIDE;
                19: it.cmd = CMD_INVOKE;
                20: it.cmd = CMD_IRETURN;
                default: it.cmd = ($urandom_range(0, 1) != 0) ? CMD_NOP : CMD_HALT;
            endcase
        // keep most local accesses inside a small frame
        if ((it.cmd == CMD_ILOAD || it.cmd == CMD_ISTORE || it.cmd == CMD_IINC)
                && $urandom_range(0, 7) != 0)
        begin
            it.hi = 8'($urandom_range(0, 5));
            if (wide_w && it.cmd != CMD_IINC)
            begin
                it.hi = 8'd0;
                it.lo = 8'($urandom_range(0, 5));
            end
        end
        if (it.cmd == CMD_INVOKE)
            case ($urandom_range(0, 7))
                0: it.nargs = 16'($urandom);
                1: it.nlocals = 16'($urandom);
                2: it.nlocals = 16'($urandom_range(3900, 4090));
                default: ;
            endcase
        return it;
    endfunction

    // Draw until the instruction touches no unwritten stack word (falling back to NOP), then commit it.
    task automatic plan_insn(output insn_t it);
        res_t r;
        undo_t u;
        int unsigned sv_sp, sv_lv;
        bit sv_wide;
        for (int tries = 0; tries <= 30; tries++)
        begin
            it = draw_insn();
            if (tries == 30)
                it.cmd = CMD_NOP;
            sv_sp = sp_w;
            sv_lv = lv_w;
            sv_wide = wide_w;
            undo_log.delete();
            execute_insn(it, r);
            if (!rd_bad)
                break;
            while (undo_log.size() != 0)
            begin
                u = undo_log.pop_back();
                stk_mem[u.a] = u.v;
                stk_wr[u.a] = u.w;
            end
            sp_w = sv_sp;
            lv_w = sv_lv;
            wide_w = sv_wide;
        end
        pending_results.push_back(r);
    endtask

    function automatic dir_row_t mk(input logic [4:0] c, input logic [15:0] pc,
                                    input logic [7:0] hi, input logic [7:0] lo,
                                    input logic [31:0] pool, input logic [15:0] nargs,
                                    input logic eof, input logic [7:0] ch, input logic known,
                                    input logic [15:0] npc, input logic h, input logic f,
                                    input logic [31:0] top);
        dir_row_t d;
        d.it = '{c, pc, hi, lo, pool, nargs, 16'd0, ch, eof};
        d.known = known;
        d.res = '{npc, 1'b0, 8'd0, h, f, top};
        return d;
    endfunction

    task automatic send_insn(input insn_t it);
        insn_ch.valid         <= 1'b1;
        insn_ch.cmd           <= it.cmd;
        insn_ch.current_pc    <= it.pc;
        insn_ch.operand_hi    <= it.hi;
        insn_ch.operand_lo    <= it.lo;
        insn_ch.pool_word     <= it.pool;
        insn_ch.method_args   <= it.nargs;
        insn_ch.method_locals <= it.nlocals;
        insn_ch.in_char       <= it.ch;
        insn_ch.in_eof        <= it.eof;
        @(posedge clk);
        while (!insn_ch.ready)
            @(posedge clk);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            insn_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        insn_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_prog_size(input logic [15:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        prog_size_w = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h (result %0d)", what, got, want, results_seen);
        mismatches++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected transaction", 32'(res_ch.next_pc), 0);
            else
            begin
                mon_exp = pending_results.pop_front();
                if (res_ch.next_pc !== mon_exp.npc)
                    report_mismatch("next_pc", 32'(res_ch.next_pc), 32'(mon_exp.npc));
                if (res_ch.out_valid !== mon_exp.ov)
                    report_mismatch("out_valid", 32'(res_ch.out_valid), 32'(mon_exp.ov));
                if (res_ch.out_char !== mon_exp.oc)
                    report_mismatch("out_char", 32'(res_ch.out_char), 32'(mon_exp.oc));
                if (res_ch.halted !== mon_exp.halted)
                    report_mismatch("halted", 32'(res_ch.halted), 32'(mon_exp.halted));
                if (res_ch.fault !== mon_exp.fault)
                    report_mismatch("fault", 32'(res_ch.fault), 32'(mon_exp.fault));
                if (res_ch.top_value !== mon_exp.top)
                    report_mismatch("top_value", res_ch.top_value, mon_exp.top);
            end
            results_seen++;
        end
    end

    // result side back-pressure, with one long hold to fill the unit
    always @(posedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
        begin
            if (!hold_done && results_seen >= 150)
            begin
                hold_done = 1;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 5);
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout with %0d transactions outstanding", pending_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        res_t r;
        insn_t it;
        logic [15:0] sizes [3];
        insn_ch.valid = 1'b0;
        insn_ch.cmd = CMD_NOP;
        insn_ch.current_pc = '0;
        insn_ch.operand_hi = '0;
        insn_ch.operand_lo = '0;
        insn_ch.pool_word = '0;
        insn_ch.method_args = '0;
        insn_ch.method_locals = '0;
        insn_ch.in_char = '0;
        insn_ch.in_eof = 1'b0;
        for (int i = 0; i < STACK_DEPTH; i++)
        begin
            stk_mem[i] = '0;
            stk_wr[i] = 1'b0;
        end
        sp_w = 0; lv_w = 0; wide_w = 0; prog_size_w = '0;
        mismatches = 0; results_seen = 0; cycles = 0;
        hold_left = 0; stall_left = 0; hold_done = 0;
        gaps_on = 1;

        //                 cmd          pc        hi     lo     pool          nargs  eof ch
        //                 known npc    h  f  top
        dir_rows[0]  = mk(CMD_POP,     16'h0000, 8'h00, 8'h00, 32'h0,        16'd0, 0, 8'h00,
                          1, 16'h1234, 1, 1, 32'h0);
        dir_rows[1]  = mk(CMD_ERR,     16'h0010, 8'h00, 8'h00, 32'h0,        16'd0, 0, 8'h00,
                          1, 16'h1234, 1, 1, 32'h0);
        dir_rows[2]  = mk(CMD_UNKNOWN, 16'h0020, 8'h00, 8'h00, 32'h0,        16'd0, 0, 8'h00,
                          1, 16'h1234, 1, 1, 32'h0);
        dir_rows[3]  = mk(CMD_HALT,    16'h0030, 8'h00, 8'h00, 32'h0,        16'd0, 0, 8'h00,
                          1, 16'h1234, 1, 0, 32'h0);
        dir_rows[4]  = mk(CMD_IRETURN, 16'h0040, 8'h00, 8'h00, 32'h0,        16'd0, 0, 8'h00,
                          1, 16'h1234, 1, 1, 32'h0);
        dir_rows[5]  = mk(CMD_NOP,     16'hFFFF, 8'h00, 8'h00, 32'h0,        16'd0, 0, 8'h00,
                          1, 16'h0000, 0, 0, 32'h0);
        dir_rows[6]  = mk(CMD_BIPUSH,  16'h0010, 8'h80, 8'h00, 32'h0,        16'd0, 0, 8'h00,
                          1, 16'h0012, 0, 0, 32'hFFFFFF80);
        dir_rows[7]  = mk(CMD_BIPUSH,  16'hFFFE, 8'h7F, 8'h00, 32'h0,        16'd0, 0, 8'h00,
                          1, 16'h0000, 0, 0, 32'h0000007F);
        dir_rows[8]  = mk(CMD_DUP,     16'h0050, 8'h00, 8'h00, 32'h0,        16'd0, 0, 8'h00,
                          0, 16'h0, 0, 0, 32'h0);
        dir_rows[9]  = mk(CMD_IADD,    16'h0060, 8'h00, 8'h00, 32'h0,        16'd0, 0, 8'h00,
                          0, 16'h0, 0, 0, 32'h0);
        dir_rows[10] = mk(CMD_SWAP,    16'h0070, 8'h00, 8'h00, 32'h0,        16'd0, 0, 8'h00,
                          0, 16'h0, 0, 0, 32'h0);
        dir_rows[11] = mk(CMD_ISUB,    16'h0080, 8'h00, 8'h00, 32'h0,        16'd0, 0, 8'h00,
                          0, 16'h0, 0, 0, 32'h0);
        dir_rows[12] = mk(CMD_LDCW,    16'h0100, 8'h00, 8'h01, 32'h80000000, 16'd0, 0, 8'h00,
                          1, 16'h0103, 0, 0, 32'h80000000);
        dir_rows[13] = mk(CMD_IN,      16'h0200, 8'h00, 8'h00, 32'h0,        16'd0, 1, 8'h55,
                          1, 16'h0201, 0, 0, 32'h0);
        dir_rows[14] = mk(CMD_IN,      16'h0300, 8'h00, 8'h00, 32'h0,        16'd0, 0, 8'hFF,
                          1, 16'h0301, 0, 0, 32'h000000FF);
        dir_rows[15] = mk(CMD_IAND,    16'h0310, 8'h00, 8'h00, 32'h0,        16'd0, 0, 8'h00,
                          0, 16'h0, 0, 0, 32'h0);
        dir_rows[16] = mk(CMD_IOR,     16'h0320, 8'h00, 8'h00, 32'h0,        16'd0, 0, 8'h00,
                          0, 16'h0, 0, 0, 32'h0);
        dir_rows[17] = mk(CMD_IFLT,    16'h0400, 8'hFF, 8'hFE, 32'h0,        16'd0, 0, 8'h00,
                          0, 16'h0, 0, 0, 32'h0);
        dir_rows[18] = mk(CMD_ICMPEQ,  16'h0500, 8'h00, 8'h10, 32'h0,        16'd0, 0, 8'h00,
                          0, 16'h0, 0, 0, 32'h0);
        dir_rows[19] = mk(CMD_WIDE,    16'h0510, 8'h00, 8'h00, 32'h0,        16'd0, 0, 8'h00,
                          0, 16'h0, 0, 0, 32'h0);
        dir_rows[20] = mk(CMD_ISTORE,  16'h0511, 8'h0F, 8'hFF, 32'h0,        16'd0, 0, 8'h00,
                          0, 16'h0, 0, 0, 32'h0);
        dir_rows[21] = mk(CMD_WIDE,    16'h0520, 8'h00, 8'h00, 32'h0,        16'd0, 0, 8'h00,
                          0, 16'h0, 0, 0, 32'h0);
        dir_rows[22] = mk(CMD_ILOAD,   16'h0521, 8'h0F, 8'hFF, 32'h0,        16'd0, 0, 8'h00,
                          0, 16'h0, 0, 0, 32'h0);
        dir_rows[23] = mk(CMD_IINC,    16'h0530, 8'h00, 8'h80, 32'h0,        16'd0, 0, 8'h00,
                          0, 16'h0, 0, 0, 32'h0);
        dir_rows[24] = mk(CMD_OUT,     16'h0540, 8'h00, 8'h00, 32'h0,        16'd0, 0, 8'h00,
                          0, 16'h0, 0, 0, 32'h0);
        dir_rows[25] = mk(CMD_INVOKE,  16'h0550, 8'h00, 8'h01, 32'h1234,     16'd257, 0, 8'h00,
                          1, 16'h1234, 1, 1, 32'h0);
        dir_rows[26] = mk(CMD_GOTO,    16'h0600, 8'h80, 8'h00, 32'h0,        16'd0, 0, 8'h00,
                          0, 16'h0, 0, 0, 32'h0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        write_prog_size(16'h1234);

        foreach (dir_rows[i])
        begin
            execute_insn(dir_rows[i].it, r);
            pending_results.push_back(dir_rows[i].known ? dir_rows[i].res : r);
            send_insn(dir_rows[i].it);
        end

        sizes[0] = 16'h0000;
        sizes[1] = 16'hFFFF;
        sizes[2] = 16'($urandom);
        for (int p = 0; p < 3; p++)
        begin
            wait_drained();
            write_prog_size(sizes[p]);
            if (p == 2)
                gaps_on = 0;
            for (int n = 0; n < RAND_PER_PHASE; n++)
            begin
                if (p == 0 && n == 100)
                    wait_drained();
                plan_insn(it);
                send_insn(it);
            end
        end
        insn_ch.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== ijvm_execute_unit.f =====
design/ijvm_eu_pkg.sv
design/ijvm_eu_if.sv
design/ijvm_eu_front.sv
design/ijvm_eu_back.sv
design/ijvm_execute_unit.sv
tb/ijvm_execute_unit_tb.sv
